FILE: sv/telnet_rx_filter_ring_defines.svh
// Assertion helpers for the telnet receive filter.
`ifndef TELNET_RX_FILTER_RING_DEFINES_SVH
`define TELNET_RX_FILTER_RING_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define TRF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define TRF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/trf_pkg.sv
`timescale 1ns / 1ps
package trf_pkg;

  // Ring geometry
  localparam int RING_DEPTH = 256;
  localparam int RING_AW    = $clog2(RING_DEPTH);
  localparam logic [7:0] FILL_MAX = 8'((RING_DEPTH - 1 > 255) ? 255 : RING_DEPTH - 1);

  // Command queue between parser and ring
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // Telnet bytes
  localparam logic [7:0] BYTE_IAC = 8'hFF;
  localparam logic [7:0] CMD_SE   = 8'd240;
  localparam logic [7:0] CMD_SB   = 8'd250;
  localparam logic [7:0] CMD_WILL = 8'd251;
  localparam logic [7:0] CMD_WONT = 8'd252;
  localparam logic [7:0] CMD_DO   = 8'd253;
  localparam logic [7:0] CMD_DONT = 8'd254;
  localparam logic [7:0] CHAR_CR  = 8'd13;
  localparam logic [7:0] CHAR_NUL = 8'd0;

  // Input action codes
  localparam logic [1:0] ACT_BYTE  = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_RESET = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_BREAK_KEY  = 2'd0;
  localparam logic [1:0] REG_SELECT_KEY = 2'd1;
  localparam logic [1:0] REG_KEY_INT_ON = 2'd2;

  // Ring operation codes
  typedef logic [2:0] trf_opc_t;
  localparam trf_opc_t OP_NONE  = 3'd0;
  localparam trf_opc_t OP_STORE = 3'd1;
  localparam trf_opc_t OP_ABORT = 3'd2;
  localparam trf_opc_t OP_KEY   = 3'd3;
  localparam trf_opc_t OP_READ  = 3'd4;

  typedef struct packed {
    trf_opc_t   opc;
    logic [7:0] data;
  } trf_op_t;

  typedef struct packed {
    logic [7:0] break_key;
    logic [7:0] select_key;
    logic       key_int_on;
  } trf_cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } trf_qstat_t;

endpackage

FILE: sv/trf_front.sv
`timescale 1ns / 1ps
module trf_front (
  input  logic              clk,
  input  logic              rst_n,
  input  trf_pkg::trf_cfg_t cfg,
  input  logic              in_valid,
  input  logic [1:0]        in_action,
  input  logic [7:0]        in_byte_in,
  input  trf_pkg::trf_qstat_t q_stat,
  output logic              in_stall,
  output logic              push,
  output trf_pkg::trf_op_t  push_op
);
  import trf_pkg::*;

  localparam logic [2:0] PS_DATA   = 3'd0;
  localparam logic [2:0] PS_IAC    = 3'd1;
  localparam logic [2:0] PS_OPT    = 3'd2;
  localparam logic [2:0] PS_SB     = 3'd3;
  localparam logic [2:0] PS_SB_IAC = 3'd4;

  logic [2:0] ps_r, ps_nxt;
  logic       cr_r, cr_nxt;
  logic       have_c;
  logic [7:0] c;

  assign in_stall = q_stat.full;
  assign push     = in_valid && !q_stat.full;

  always_comb begin
    ps_nxt  = ps_r;
    cr_nxt  = cr_r;
    have_c  = 1'b0;
    c       = in_byte_in;
    push_op = '{opc: OP_NONE, data: in_byte_in};
    unique case (in_action)
      ACT_BYTE: begin
        unique case (ps_r)
          PS_DATA: begin
            if (in_byte_in == BYTE_IAC) ps_nxt = PS_IAC;
            else have_c = 1'b1;
          end
          PS_IAC: begin
            if (in_byte_in == BYTE_IAC) begin
              have_c = 1'b1;
              ps_nxt = PS_DATA;
            end else if (in_byte_in == CMD_SB) begin
              ps_nxt = PS_SB;
            end else if (in_byte_in == CMD_WILL || in_byte_in == CMD_WONT ||
                         in_byte_in == CMD_DO || in_byte_in == CMD_DONT) begin
              ps_nxt = PS_OPT;
            end else begin
              ps_nxt = PS_DATA;
            end
          end
          PS_OPT:    ps_nxt = PS_DATA;
          PS_SB:     if (in_byte_in == BYTE_IAC) ps_nxt = PS_SB_IAC;
          PS_SB_IAC: ps_nxt = (in_byte_in == CMD_SE) ? PS_DATA : PS_SB;
          default:   ps_nxt = PS_DATA;
        endcase
        if (have_c) begin
          priority if (cr_r && c == CHAR_NUL) begin
            cr_nxt = 1'b0;
          end else if (cfg.break_key != 8'd0 && c == cfg.break_key) begin
            cr_nxt      = 1'b0;
            push_op.opc = OP_ABORT;
          end else if (cfg.key_int_on && c == cfg.select_key) begin
            cr_nxt      = 1'b0;
            push_op.opc = OP_KEY;
          end else begin
            cr_nxt      = (c == CHAR_CR);
            push_op.opc = OP_STORE;
          end
        end
      end
      ACT_READ: push_op.opc = OP_READ;
      ACT_RESET: begin
        ps_nxt = PS_DATA;
        cr_nxt = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ps_r <= PS_DATA;
      cr_r <= 1'b0;
    end else if (push) begin
      ps_r <= ps_nxt;
      cr_r <= cr_nxt;
    end
  end

endmodule

FILE: sv/trf_queue.sv
`timescale 1ns / 1ps
module trf_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  trf_pkg::trf_op_t    push_op,
  input  logic                pop,
  output trf_pkg::trf_op_t    pop_op,
  output trf_pkg::trf_qstat_t q_stat
);
  import trf_pkg::*;

  trf_op_t        slot_r [QDEPTH];
  logic [QAW-1:0] wr_r, rd_r;
  logic [QAW:0]   cnt_r;

  function automatic logic [QAW-1:0] qinc(input logic [QAW-1:0] p);
    return (p == QAW'(QDEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign q_stat.full  = (cnt_r == (QAW+1)'(QDEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign pop_op       = slot_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_r] <= push_op;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= qinc(wr_r);
      if (pop)  rd_r <= qinc(rd_r);
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

FILE: sv/trf_back.sv
`timescale 1ns / 1ps
module trf_back (
  input  logic                clk,
  input  logic                rst_n,
  input  trf_pkg::trf_op_t    pop_op,
  input  trf_pkg::trf_qstat_t q_stat,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_read_valid,
  output logic [7:0]          out_read_byte,
  output logic                out_stored,
  output logic                out_overflowed,
  output logic                out_abort_raised,
  output logic                out_key_complete,
  output logic [7:0]          out_fill_count
);
  import trf_pkg::*;

  logic [7:0]         ring_mem [RING_DEPTH];
  logic [RING_AW-1:0] head_r, head_nxt, tail_r, tail_nxt, head_inc;
  logic [RING_AW:0]   fill;
  logic [7:0]         fill_sat;
  logic               exec;
  logic               rv, st, ov, ab, kc;

  logic       out_valid_r, rv_r, st_r, ov_r, ab_r, kc_r;
  logic [7:0] fill_r, rd_data_r;

  function automatic logic [RING_AW-1:0] rinc(input logic [RING_AW-1:0] p);
    return (p == RING_AW'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign exec = !q_stat.empty && (!out_valid_r || !out_stall);
  assign pop  = exec;
  assign head_inc = rinc(head_r);

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    rv = 1'b0;
    st = 1'b0;
    ov = 1'b0;
    ab = 1'b0;
    kc = 1'b0;
    unique case (pop_op.opc)
      OP_STORE: begin
        st       = 1'b1;
        head_nxt = head_inc;
        if (head_inc == tail_r) begin
          ov       = 1'b1;
          tail_nxt = rinc(tail_r);
        end
      end
      OP_ABORT: begin
        ab       = 1'b1;
        head_nxt = tail_r;
      end
      OP_KEY: kc = 1'b1;
      OP_READ: begin
        if (head_r != tail_r) begin
          rv       = 1'b1;
          tail_nxt = rinc(tail_r);
        end
      end
      default: ;
    endcase
    if (head_nxt >= tail_nxt) fill = {1'b0, head_nxt} - {1'b0, tail_nxt};
    else fill = {1'b0, head_nxt} + (RING_AW+1)'(RING_DEPTH) - {1'b0, tail_nxt};
    fill_sat = (32'(fill) > 32'd255) ? 8'hFF : 8'(fill);
  end

  // ring storage; read data lands with the result register
  always_ff @(posedge clk) begin
    if (exec && pop_op.opc == OP_STORE) ring_mem[head_r] <= pop_op.data;
    if (exec && pop_op.opc == OP_READ)  rd_data_r <= ring_mem[tail_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (exec) begin
        head_r <= head_nxt;
        tail_r <= tail_nxt;
      end
      if (exec) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      rv_r   <= rv;
      st_r   <= st;
      ov_r   <= ov;
      ab_r   <= ab;
      kc_r   <= kc;
      fill_r <= fill_sat;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_read_valid   = rv_r;
  assign out_read_byte    = rv_r ? rd_data_r : 8'd0;
  assign out_stored       = st_r;
  assign out_overflowed   = ov_r;
  assign out_abort_raised = ab_r;
  assign out_key_complete = kc_r;
  assign out_fill_count   = fill_r;

endmodule

FILE: sv/telnet_rx_filter_ring.sv
// Throughput: one item per cycle when neither channel stalls; the ring takes
// one write or one read per cycle. A four-entry op queue lets the parser keep
// accepting while the output is stalled, until the queue fills.
// Reset (rst_n low, synchronous): parser to data state, CR flag, ring pointers,
// queue and output valid cleared; config back to break 3, select 0, key int off.
// Ring contents are not cleared and need no clearing pass.
`timescale 1ns / 1ps
`include "telnet_rx_filter_ring_defines.svh"
module telnet_rx_filter_ring (
  input  logic       clk,
  input  logic       rst_n,
  // config write port
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_wdata,
  // input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_action,
  input  logic [7:0] in_byte_in,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_read_valid,
  output logic [7:0] out_read_byte,
  output logic       out_stored,
  output logic       out_overflowed,
  output logic       out_abort_raised,
  output logic       out_key_complete,
  output logic [7:0] out_fill_count
);
  import trf_pkg::*;

  // config registers
  logic [7:0] break_key_r, select_key_r;
  logic       key_int_on_r;
  trf_cfg_t   cfg;

  // front/back link
  logic       push, pop;
  trf_op_t    push_op, pop_op;
  trf_qstat_t q_stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      break_key_r  <= 8'd3;
      select_key_r <= 8'd0;
      key_int_on_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BREAK_KEY:  break_key_r  <= cfg_wdata;
        REG_SELECT_KEY: select_key_r <= cfg_wdata;
        REG_KEY_INT_ON: key_int_on_r <= cfg_wdata[0];
        default: ;  // unmapped index: ignored
      endcase
    end
  end

  assign cfg = '{break_key: break_key_r, select_key: select_key_r, key_int_on: key_int_on_r};

  // Front: telnet command stripping, CR/NUL handling and key checks.
  // Every item becomes exactly one ring op (possibly a no-op).
  trf_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_action  (in_action),
    .in_byte_in (in_byte_in),
    .q_stat     (q_stat),
    .in_stall   (in_stall),
    .push       (push),
    .push_op    (push_op)
  );

  trf_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .pop_op  (pop_op),
    .q_stat  (q_stat)
  );

  // Back: ring memory, head/tail pointers and the result register.
  trf_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .pop_op           (pop_op),
    .q_stat           (q_stat),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_read_valid   (out_read_valid),
    .out_read_byte    (out_read_byte),
    .out_stored       (out_stored),
    .out_overflowed   (out_overflowed),
    .out_abort_raised (out_abort_raised),
    .out_key_complete (out_key_complete),
    .out_fill_count   (out_fill_count)
  );

  // overflow only on a store into a full ring
  `TRF_ASSERT_NOW(a_ovf_full, out_valid && out_overflowed, out_stored && out_fill_count == FILL_MAX, "overflow without full store")
  // abort leaves the ring empty
  `TRF_ASSERT_NOW(a_abort_empty, out_valid && out_abort_raised, out_fill_count == 8'd0 && !out_stored, "abort left bytes in ring")
  // a pending op with a free output register is always drained
  `TRF_ASSERT_NEXT(a_drain, !q_stat.empty && !out_valid, out_valid, "queued op not executed")
  // a queue that is full never takes another op
  `TRF_ASSERT_NOW(a_no_push_full, q_stat.full, !push, "push into full queue")

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import trf_pkg::*;

  // Action code that the block treats as a no-op.
  localparam logic [1:0] ACT_SPARE = 2'd3;
  // Cycles with no handshake on either channel before the run is called hung.
  localparam int WATCHDOG_LIMIT = 5000;
  // Long receiver hold-off so the op queue fills and the input stalls.
  localparam int HOLD_CYCLES = 400;

  // Parser states of the local predictor.
  typedef enum logic [2:0] {
    P_DATA, P_IAC, P_OPT, P_SB, P_SB_IAC
  } parse_st_t;

  // One item as the sender offers it.
  typedef struct {
    logic [1:0] act;
    logic [7:0] b;
  } net_item_t;

  // One result item, packed so the whole line compares at once.
  typedef struct packed {
    logic       rd_ok;
    logic [7:0] rd_byte;
    logic       stored;
    logic       ovf;
    logic       abort;
    logic       key_done;
    logic [7:0] fill;
  } line_res_t;

  // DUT pins; every input starts at a known value.
  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [7:0] cfg_wdata = '0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] in_action = '0;
  logic [7:0] in_byte_in = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_read_valid;
  logic [7:0] out_read_byte;
  logic       out_stored;
  logic       out_overflowed;
  logic       out_abort_raised;
  logic       out_key_complete;
  logic [7:0] out_fill_count;

  telnet_rx_filter_ring u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_byte_in       (in_byte_in),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_read_valid   (out_read_valid),
    .out_read_byte    (out_read_byte),
    .out_stored       (out_stored),
    .out_overflowed   (out_overflowed),
    .out_abort_raised (out_abort_raised),
    .out_key_complete (out_key_complete),
    .out_fill_count   (out_fill_count)
  );

  // 2 ns clock.
  initial begin
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: a private copy of the parser, the ring and the key registers.
  // Initial values match what reset gives.
  // ---------------------------------------------------------------------------
  logic [7:0]         brk_key = 8'd3;
  logic [7:0]         sel_key = 8'd0;
  logic               key_int = 1'b0;
  parse_st_t          p_state = P_DATA;
  logic               cr_seen = 1'b0;
  logic [7:0]         ring_mem [RING_DEPTH];
  logic [RING_AW-1:0] wr_ptr = '0;
  logic [RING_AW-1:0] rd_ptr = '0;

  // Testbench bookkeeping.
  net_item_t tx_items[$];      // items waiting for the driver
  line_res_t exp_results[$];   // predicted result items, oldest first
  int        n_queued = 0;     // items handed to the driver
  int        n_taken = 0;      // items the block has accepted
  int        n_bad = 0;        // failed checks
  int        idle_cyc = 0;     // watchdog count
  bit        in_fired = 1'b0;  // input handshake seen at the last rising edge
  int        src_idle_pct = 0;
  int        snk_idle_pct = 0;
  bit        hold_req = 1'b0;  // asks the stall process for one long hold-off
  int        hold_cnt = 0;

  // A data byte that got past command stripping: dropped NUL, break key,
  // select key, or a ring write that may push out the oldest byte.
  function automatic void push_data(input logic [7:0] c, inout line_res_t r);
    if (cr_seen && c == CHAR_NUL) begin
      cr_seen = 1'b0;
    end else if (brk_key != 8'd0 && c == brk_key) begin
      // break wins over select; flush by pulling the read side up
      rd_ptr = wr_ptr;
      cr_seen = 1'b0;
      r.abort = 1'b1;
    end else if (key_int && c == sel_key) begin
      cr_seen = 1'b0;
      r.key_done = 1'b1;
    end else begin
      ring_mem[wr_ptr] = c;
      cr_seen = (c == CHAR_CR);
      wr_ptr++;
      r.stored = 1'b1;
      if (wr_ptr == rd_ptr) begin
        rd_ptr++;
        r.ovf = 1'b1;
      end
    end
  endfunction

  // Expected result item for one accepted item; advances the predictor state.
  function automatic line_res_t predict_line(input logic [1:0] act, input logic [7:0] b);
    line_res_t   r;
    int unsigned n;
    r = '0;
    case (act)
      ACT_BYTE: begin
        case (p_state)
          P_DATA: begin
            if (b == BYTE_IAC) p_state = P_IAC;
            else push_data(b, r);
          end
          P_IAC: begin
            if (b == BYTE_IAC) begin
              // escaped 0xFF is plain data
              push_data(BYTE_IAC, r);
              p_state = P_DATA;
            end else if (b == CMD_SB) begin
              p_state = P_SB;
            end else if (b == CMD_WILL || b == CMD_WONT ||
                         b == CMD_DO || b == CMD_DONT) begin
              p_state = P_OPT;
            end else begin
              p_state = P_DATA;
            end
          end
          P_OPT: p_state = P_DATA;
          P_SB: begin
            if (b == BYTE_IAC) p_state = P_SB_IAC;
          end
          P_SB_IAC: p_state = (b == CMD_SE) ? P_DATA : P_SB;
          default: p_state = P_DATA;
        endcase
      end
      ACT_READ: begin
        // empty ring: nothing popped, fields stay 0
        if (wr_ptr != rd_ptr) begin
          r.rd_ok = 1'b1;
          r.rd_byte = ring_mem[rd_ptr];
          rd_ptr++;
        end
      end
      ACT_RESET: begin
        // parser only; the ring keeps its bytes
        p_state = P_DATA;
        cr_seen = 1'b0;
      end
      default: ;
    endcase
    n = 32'(RING_AW'(wr_ptr - rd_ptr));
    r.fill = (n > 255) ? 8'd255 : 8'(n);
    return r;
  endfunction

  task automatic queue_item(input logic [1:0] act, input logic [7:0] b);
    net_item_t it;
    it.act = act;
    it.b = b;
    tx_items.push_back(it);
    n_queued++;
  endtask

  // Register write on the config port; the block is idle whenever this runs.
  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_BREAK_KEY:  brk_key = val;
      REG_SELECT_KEY: sel_key = val;
      REG_KEY_INT_ON: key_int = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_keys(input logic [7:0] brk, input logic [7:0] sel, input logic ki);
    write_reg(REG_BREAK_KEY, brk);
    write_reg(REG_SELECT_KEY, sel);
    write_reg(REG_KEY_INT_ON, {7'd0, ki});
  endtask

  // Wait until every queued item went in and its result came back.
  // Checked on the falling edge, away from the handshake edge.
  task automatic drain();
    while (n_taken != n_queued || exp_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Random traffic shaped like a telnet stream: mostly text runs and
  // well-formed negotiation, with broken subnegotiation, stray IACs,
  // CR/NUL pairs, key bytes, reads and session resets mixed in.
  task automatic gen_traffic(input int n_items, input int read_pct);
    int start, r, k, len;
    start = n_queued;
    while (n_queued - start < n_items) begin
      r = $urandom_range(0, 99);
      if (r < read_pct) begin
        len = $urandom_range(1, 8);
        for (k = 0; k < len; k++) queue_item(ACT_READ, 8'($urandom));
      end else if (r < read_pct + 4) begin
        queue_item(ACT_RESET, 8'($urandom));
      end else if (r < read_pct + 6) begin
        queue_item(ACT_SPARE, 8'($urandom));
      end else if (r < read_pct + 14) begin
        // WILL/WONT/DO/DONT + option
        queue_item(ACT_BYTE, BYTE_IAC);
        queue_item(ACT_BYTE, 8'($urandom_range(CMD_WILL, CMD_DONT)));
        queue_item(ACT_BYTE, 8'($urandom));
      end else if (r < read_pct + 19) begin
        // subnegotiation; sometimes left open
        queue_item(ACT_BYTE, BYTE_IAC);
        queue_item(ACT_BYTE, CMD_SB);
        len = $urandom_range(0, 6);
        for (k = 0; k < len; k++) begin
          if ($urandom_range(0, 7) == 0) queue_item(ACT_BYTE, BYTE_IAC);
          queue_item(ACT_BYTE, 8'($urandom));
        end
        if ($urandom_range(0, 5) != 0) begin
          queue_item(ACT_BYTE, BYTE_IAC);
          queue_item(ACT_BYTE, CMD_SE);
        end
      end else if (r < read_pct + 23) begin
        queue_item(ACT_BYTE, BYTE_IAC);
        queue_item(ACT_BYTE, BYTE_IAC);
      end else if (r < read_pct + 26) begin
        queue_item(ACT_BYTE, BYTE_IAC);
        queue_item(ACT_BYTE, 8'($urandom));
      end else if (r < read_pct + 31) begin
        queue_item(ACT_BYTE, CHAR_CR);
        queue_item(ACT_BYTE, ($urandom_range(0, 1) != 0) ? CHAR_NUL : 8'($urandom));
      end else if (r < read_pct + 35) begin
        queue_item(ACT_BYTE, ($urandom_range(0, 1) != 0) ? brk_key : sel_key);
      end else begin
        // text run, with some raw bytes as noise
        len = $urandom_range(1, 12);
        for (k = 0; k < len; k++) begin
          if ($urandom_range(0, 4) != 0)
            queue_item(ACT_BYTE, 8'($urandom_range(8'h20, 8'h7E)));
          else queue_item(ACT_BYTE, 8'($urandom));
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: moves to the next item once the current one was taken.
  // Payload changes only on the falling edge and never while stalled.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    net_item_t nx;
    if (!in_valid || in_fired) begin
      if (tx_items.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
        nx = tx_items.pop_front();
        in_valid <= 1'b1;
        in_action <= nx.act;
        in_byte_in <= nx.b;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall: random, plus one long hold-off when asked.
  always @(negedge clk) begin
    if (hold_req && hold_cnt < HOLD_CYCLES) begin
      out_stall <= 1'b1;
      hold_cnt++;
    end else begin
      out_stall <= ($urandom_range(0, 99) < snk_idle_pct);
    end
  end

  task automatic note_miss(input string why, input line_res_t got, input line_res_t want);
    string exp_s, got_s;
    n_bad++;
    if (n_bad <= 10) begin
      exp_s = $sformatf("rv=%0d rb=%02h st=%0d ov=%0d ab=%0d kc=%0d fc=%0d",
                        want.rd_ok, want.rd_byte, want.stored, want.ovf, want.abort,
                        want.key_done, want.fill);
      got_s = $sformatf("rv=%0d rb=%02h st=%0d ov=%0d ab=%0d kc=%0d fc=%0d",
                        got.rd_ok, got.rd_byte, got.stored, got.ovf, got.abort,
                        got.key_done, got.fill);
      $display("%0t %s: exp %s  got %s", $realtime, why, exp_s, got_s);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: both handshakes sampled at the rising edge. An accepted item
  // is predicted right away; an accepted result is checked against the
  // oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    line_res_t got, want;
    bit        out_fired;
    in_fired = in_valid && !in_stall;
    out_fired = out_valid && !out_stall;
    if (out_fired) begin
      got.rd_ok = out_read_valid;
      got.rd_byte = out_read_byte;
      got.stored = out_stored;
      got.ovf = out_overflowed;
      got.abort = out_abort_raised;
      got.key_done = out_key_complete;
      got.fill = out_fill_count;
      if (exp_results.size() == 0) begin
        note_miss("result with no item pending", got, '0);
      end else begin
        want = exp_results.pop_front();
        if (got !== want) note_miss("mismatch", got, want);
      end
    end
    if (in_fired) begin
      exp_results.push_back(predict_line(in_action, in_byte_in));
      n_taken++;
    end
    if (in_fired || out_fired) idle_cyc = 0;
    else idle_cyc++;
    if (idle_cyc >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence. Register writes only happen between phases, once the
  // block has drained.
  // ---------------------------------------------------------------------------
  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Phase 0: reset keys (break 3, select 0, key interrupt off).
    // Sender idles lightly, receiver heavily.
    src_idle_pct = 10;
    snk_idle_pct = 61;
    queue_item(ACT_READ, 8'hA5);      // read on empty ring
    queue_item(ACT_BYTE, 8'h41);
    queue_item(ACT_BYTE, CHAR_NUL);   // NUL with no CR before it is kept
    queue_item(ACT_BYTE, CHAR_CR);
    queue_item(ACT_BYTE, CHAR_NUL);   // dropped after CR
    queue_item(ACT_BYTE, BYTE_IAC);   // IAC IAC -> literal 0xFF
    queue_item(ACT_BYTE, BYTE_IAC);
    queue_item(ACT_BYTE, BYTE_IAC);   // option negotiation
    queue_item(ACT_BYTE, CMD_WILL);
    queue_item(ACT_BYTE, 8'h01);
    queue_item(ACT_BYTE, BYTE_IAC);   // subnegotiation with an inner IAC
    queue_item(ACT_BYTE, CMD_SB);
    queue_item(ACT_BYTE, 8'h18);
    queue_item(ACT_BYTE, BYTE_IAC);
    queue_item(ACT_BYTE, 8'hAA);
    queue_item(ACT_BYTE, BYTE_IAC);
    queue_item(ACT_BYTE, CMD_SE);
    queue_item(ACT_BYTE, BYTE_IAC);   // plain command, back to data
    queue_item(ACT_BYTE, 8'hF1);
    queue_item(ACT_BYTE, 8'h03);      // break key: abort and flush
    queue_item(ACT_BYTE, BYTE_IAC);   // session reset mid-command
    queue_item(ACT_RESET, 8'h5A);
    queue_item(ACT_BYTE, 8'h42);
    queue_item(ACT_SPARE, 8'hFF);     // unused action code
    queue_item(ACT_READ, 8'h00);
    gen_traffic(340, 25);
    drain();

    // Phase 1: break off, select key zero with key interrupt on; few reads.
    set_keys(8'd0, 8'd0, 1'b1);
    queue_item(ACT_BYTE, CHAR_NUL);   // key-complete
    queue_item(ACT_BYTE, CHAR_CR);
    queue_item(ACT_BYTE, CHAR_NUL);   // dropped, not a key
    gen_traffic(360, 4);
    drain();

    // Phase 2: one byte is both keys; now the sender idles more.
    src_idle_pct = 61;
    snk_idle_pct = 10;
    set_keys(8'h55, 8'h55, 1'b1);
    queue_item(ACT_BYTE, 8'h55);      // break wins
    gen_traffic(360, 15);
    drain();

    // Phase 3: top key values, no idling, and one long receiver hold-off
    // while the sender keeps offering items.
    src_idle_pct = 0;
    snk_idle_pct = 0;
    set_keys(8'hFF, 8'hFE, 1'b1);
    hold_req = 1'b1;
    queue_item(ACT_BYTE, BYTE_IAC);   // escaped 0xFF hits the break key
    queue_item(ACT_BYTE, BYTE_IAC);
    gen_traffic(360, 3);
    drain();

    // Phase 4: select key 0xFF but key interrupt off.
    set_keys(8'h01, 8'hFF, 1'b0);
    gen_traffic(360, 30);
    drain();

    if (n_bad == 0 && exp_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
